/* rtl/core/generational_handle_table_unit_defines.svh */
// Assertion macros for the generational handle table unit.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GHTU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ghtu port check failed");

// Next-cycle implication, disabled while in reset.
`define GHTU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ghtu port check failed");

`endif

/* rtl/core/ghtu_pkg.sv */
// Shared types and constants of the generational handle table unit.
// No dependencies; the free map, sequencer, top and checker refer to it by scoped names.
`timescale 1ns / 1ps

package ghtu_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned REQ_BITS       = 3;
  localparam int unsigned IDX_BITS       = 6;
  localparam int unsigned PORT_GEN_BITS  = 16;
  localparam int unsigned TAG_BITS       = 4;
  localparam int unsigned PORT_ELEM_BITS = 32;
  localparam int unsigned STATUS_BITS    = 2;

  // Free bitmap row geometry
  localparam int unsigned FREE_ROW_SHIFT = 5;
  localparam int unsigned FREE_ROW_BITS  = 1 << FREE_ROW_SHIFT;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_INSERT     = 3'd0,
    REQ_INSERT_NEW = 3'd1,
    REQ_REMOVE     = 3'd2,
    REQ_GET_HANDLE = 3'd3,
    REQ_GET_INDEX  = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CFG_HANDLE_KIND = 1'b0,
    CFG_DATA_KIND   = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_FIND = 2'd1,
    S_SLOT = 2'd2
  } state_e;

  // Control from the sequencer to the free map
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } fm_ctrl_t;

endpackage

/* rtl/core/ghtu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; instanced for the slot store and the free bitmap.
`timescale 1ns / 1ps

module ghtu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ghtu_free_map.sv */
// Free-slot bitmap: one RAM row per 32 slots plus a per-row summary.
// Depends on ghtu_pkg and ghtu_ram.
`timescale 1ns / 1ps

module ghtu_free_map #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned NROWS   = (CAPACITY + ghtu_pkg::FREE_ROW_BITS - 1) /
                                    ghtu_pkg::FREE_ROW_BITS,
  localparam int unsigned ROW_AW  = (NROWS > 1) ? $clog2(NROWS) : 1,
  localparam int unsigned GW      = ROW_AW + ghtu_pkg::FREE_ROW_SHIFT,
  localparam int unsigned CMP_W   = GW + 1,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ghtu_pkg::fm_ctrl_t                   ctrl_i,
  input  logic [ROW_AW-1:0]                    rd_row_i,
  input  logic [ROW_AW-1:0]                    wr_row_i,
  input  logic [ghtu_pkg::FREE_ROW_BITS-1:0]   wr_bits_i,
  input  logic [CNT_W-1:0]                     used_i,
  output logic                                 any_free_o,
  output logic [ROW_AW-1:0]                    first_row_o,
  output logic [ghtu_pkg::FREE_ROW_BITS-1:0]   rd_bits_o,
  output logic [ghtu_pkg::FREE_ROW_SHIFT-1:0]  first_bit_o
);

  logic [NROWS-1:0]                    summary_q;
  logic [ROW_AW-1:0]                   rd_row_q;
  logic [ghtu_pkg::FREE_ROW_BITS-1:0]  wr_mask;
  logic [ghtu_pkg::FREE_ROW_BITS-1:0]  rd_mask;
  logic [ghtu_pkg::FREE_ROW_BITS-1:0]  rd_live;
  logic [CMP_W-1:0]                    used_ext;

  assign used_ext = CMP_W'(used_i);

  ghtu_ram #(
    .WIDTH (ghtu_pkg::FREE_ROW_BITS),
    .DEPTH (NROWS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (wr_row_i),
    .wdata_i (wr_bits_i),
    .re_i    (ctrl_i.rd_en),
    .raddr_i (rd_row_i),
    .rdata_o (rd_bits_o)
  );

  // Mask off bits of slots at or beyond the used count
  always_comb begin
    for (int j = 0; j < ghtu_pkg::FREE_ROW_BITS; j++) begin
      wr_mask[j] = CMP_W'({wr_row_i, ghtu_pkg::FREE_ROW_SHIFT'(j)}) < used_ext;
      rd_mask[j] = CMP_W'({rd_row_q, ghtu_pkg::FREE_ROW_SHIFT'(j)}) < used_ext;
    end
  end

  assign rd_live = rd_bits_o & rd_mask;

  // Track the row of the data sitting on the read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_row_q <= rd_row_i;
    end
  end

  // Summary: one bit per row that holds a live free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q <= '0;
    end else if (ctrl_i.clear) begin
      summary_q <= '0;
    end else if (ctrl_i.wr_en) begin
      summary_q[wr_row_i] <= |(wr_bits_i & wr_mask);
    end
  end

  // Lowest row with a free slot
  always_comb begin
    first_row_o = '0;
    for (int r = NROWS - 1; r >= 0; r--) begin
      if (summary_q[r]) begin
        first_row_o = ROW_AW'(r);
      end
    end
  end

  assign any_free_o = |summary_q;

  // Lowest free slot within the row just read
  always_comb begin
    first_bit_o = '0;
    for (int j = ghtu_pkg::FREE_ROW_BITS - 1; j >= 0; j--) begin
      if (rd_live[j]) begin
        first_bit_o = ghtu_pkg::FREE_ROW_SHIFT'(j);
      end
    end
  end

endmodule

/* rtl/core/ghtu_seq.sv */
// Request sequencer: FSM, request latch, used count, slot RMW, response register.
// Depends on ghtu_pkg; drives the slot RAM and the free map.
`timescale 1ns / 1ps

module ghtu_seq #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned GEN_BITS  = 16,
  parameter int unsigned ELEM_BITS = 32,
  localparam int unsigned IDX_W    = $clog2(CAPACITY),
  localparam int unsigned NROWS    = (CAPACITY + ghtu_pkg::FREE_ROW_BITS - 1) /
                                     ghtu_pkg::FREE_ROW_BITS,
  localparam int unsigned ROW_AW   = (NROWS > 1) ? $clog2(NROWS) : 1,
  localparam int unsigned GW       = ROW_AW + ghtu_pkg::FREE_ROW_SHIFT,
  localparam int unsigned CMP_W    = GW + 1,
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1),
  localparam int unsigned SW       = 1 + GEN_BITS + ELEM_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ghtu_pkg::REQ_BITS-1:0]          req_type_i,
  input  logic [ghtu_pkg::IDX_BITS-1:0]          slot_index_i,
  input  logic [ghtu_pkg::PORT_GEN_BITS-1:0]     slot_generation_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]          handle_kind_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]          data_kind_i,
  input  logic [ghtu_pkg::PORT_ELEM_BITS-1:0]    element_value_i,
  // response channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [ghtu_pkg::STATUS_BITS-1:0]       status_o,
  output logic [ghtu_pkg::IDX_BITS-1:0]          out_index_o,
  output logic [ghtu_pkg::PORT_GEN_BITS-1:0]     out_generation_o,
  output logic [ghtu_pkg::TAG_BITS-1:0]          out_handle_kind_o,
  output logic [ghtu_pkg::TAG_BITS-1:0]          out_data_kind_o,
  output logic                                   handle_valid_o,
  output logic [ghtu_pkg::PORT_ELEM_BITS-1:0]    out_element_o,
  // configured tags
  input  logic [ghtu_pkg::TAG_BITS-1:0]          hk_tag_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]          dk_tag_i,
  // slot RAM
  output logic                                   slot_re_o,
  output logic [IDX_W-1:0]                       slot_raddr_o,
  input  logic [SW-1:0]                          slot_rdata_i,
  output logic                                   slot_we_o,
  output logic [IDX_W-1:0]                       slot_waddr_o,
  output logic [SW-1:0]                          slot_wdata_o,
  // free map
  output ghtu_pkg::fm_ctrl_t                     fm_ctrl_o,
  output logic [ROW_AW-1:0]                      fm_rd_row_o,
  output logic [ROW_AW-1:0]                      fm_wr_row_o,
  output logic [ghtu_pkg::FREE_ROW_BITS-1:0]     fm_wr_bits_o,
  output logic [CNT_W-1:0]                       used_o,
  input  logic                                   fm_any_free_i,
  input  logic [ROW_AW-1:0]                      fm_first_row_i,
  input  logic [ghtu_pkg::FREE_ROW_BITS-1:0]     fm_rd_bits_i,
  input  logic [ghtu_pkg::FREE_ROW_SHIFT-1:0]    fm_first_bit_i
);

  localparam int unsigned GCMP_W = (GEN_BITS > ghtu_pkg::PORT_GEN_BITS) ?
                                   GEN_BITS : ghtu_pkg::PORT_GEN_BITS;
  localparam int unsigned RS     = ghtu_pkg::FREE_ROW_SHIFT;

  typedef struct packed {
    ghtu_pkg::status_e                       status;
    logic [ghtu_pkg::IDX_BITS-1:0]           index;
    logic [ghtu_pkg::PORT_GEN_BITS-1:0]      gen;
    logic [ghtu_pkg::TAG_BITS-1:0]           hk;
    logic [ghtu_pkg::TAG_BITS-1:0]           dk;
    logic                                    valid;
    logic [ghtu_pkg::PORT_ELEM_BITS-1:0]     elem;
  } res_t;

  ghtu_pkg::state_e state_q, state_d;

  // request latch
  logic [ghtu_pkg::REQ_BITS-1:0]       req_q;
  logic [ghtu_pkg::IDX_BITS-1:0]       idx_q;
  logic [ghtu_pkg::PORT_GEN_BITS-1:0]  gen_q;
  logic [ghtu_pkg::TAG_BITS-1:0]       hk_q;
  logic [ghtu_pkg::TAG_BITS-1:0]       dk_q;
  logic [ELEM_BITS-1:0]                elem_q;
  logic                                have_free_q;
  logic [ROW_AW-1:0]                   row_q, row_d;
  logic [RS-1:0]                       bit_q, bit_d;
  logic                                latch_req, latch_bit;

  logic [CNT_W-1:0] used_q, used_d;

  res_t res_q, res_d;
  logic out_valid_q, out_load, out_free;

  // decode helpers
  logic                  accept, is_ins_i;
  logic [GW-1:0]         idx_g_i, idx_g_q;
  logic [CMP_W-1:0]      used_g;
  logic                  word_free;
  logic [GEN_BITS-1:0]   word_gen, gen_inc;
  logic [ELEM_BITS-1:0]  word_elem;
  logic                  in_range, tags_ok, gen_ok, hval, ival, is_full;
  logic [ghtu_pkg::FREE_ROW_BITS-1:0] bit_mask;

  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign is_ins_i  = (req_type_i == ghtu_pkg::REQ_INSERT) ||
                     (req_type_i == ghtu_pkg::REQ_INSERT_NEW);

  assign idx_g_i   = GW'(slot_index_i);
  assign idx_g_q   = GW'(idx_q);
  assign used_g    = CMP_W'(used_q);

  assign word_free = slot_rdata_i[SW-1];
  assign word_gen  = slot_rdata_i[ELEM_BITS +: GEN_BITS];
  assign word_elem = slot_rdata_i[ELEM_BITS-1:0];
  assign gen_inc   = word_gen + GEN_BITS'(1);

  // Handle validity against the slot word just read
  assign in_range  = CMP_W'(idx_g_q) < used_g;
  assign tags_ok   = (hk_q == hk_tag_i) && (dk_q == dk_tag_i);
  assign gen_ok    = GCMP_W'(word_gen) == GCMP_W'(gen_q);
  assign hval      = tags_ok && in_range && !word_free && gen_ok;
  assign ival      = in_range && !word_free;
  assign is_full   = used_q == CNT_W'(CAPACITY);
  assign bit_mask  = ghtu_pkg::FREE_ROW_BITS'(1) << bit_q;

  // Next state
  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      ghtu_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = is_ins_i ? ghtu_pkg::S_FIND : ghtu_pkg::S_SLOT;
        end
      end
      ghtu_pkg::S_FIND: begin
        if (have_free_q) begin
          state_d = ghtu_pkg::S_SLOT;
        end else if (out_free) begin
          state_d = ghtu_pkg::S_IDLE;
        end
      end
      ghtu_pkg::S_SLOT: begin
        if (out_free) begin
          state_d = ghtu_pkg::S_IDLE;
        end
      end
      default: state_d = ghtu_pkg::S_IDLE;
    endcase
  end

  // Datapath control and response assembly
  always_comb begin : outputs
    in_ready_o   = 1'b0;
    slot_re_o    = 1'b0;
    slot_raddr_o = idx_g_i[IDX_W-1:0];
    slot_we_o    = 1'b0;
    slot_waddr_o = idx_g_q[IDX_W-1:0];
    slot_wdata_o = slot_rdata_i;
    fm_ctrl_o    = '0;
    fm_rd_row_o  = idx_g_i[GW-1:RS];
    fm_wr_row_o  = row_q;
    fm_wr_bits_o = fm_rd_bits_i;
    latch_req    = 1'b0;
    latch_bit    = 1'b0;
    row_d        = row_q;
    bit_d        = bit_q;
    used_d       = used_q;
    out_load     = 1'b0;
    res_d        = '0;

    unique case (state_q)
      ghtu_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // Read the slot word and the bitmap row this request needs
          latch_req       = 1'b1;
          latch_bit       = 1'b1;
          slot_re_o       = 1'b1;
          fm_ctrl_o.rd_en = 1'b1;
          if (is_ins_i) begin
            fm_rd_row_o = fm_any_free_i ? fm_first_row_i : used_g[GW-1:RS];
            bit_d       = used_g[RS-1:0];
          end else begin
            bit_d       = idx_g_i[RS-1:0];
          end
          row_d = fm_rd_row_o;
        end
      end

      ghtu_pkg::S_FIND: begin
        if (have_free_q) begin
          // Reuse the lowest free slot: fetch its word
          slot_re_o    = 1'b1;
          slot_raddr_o = IDX_W'({row_q, fm_first_bit_i});
          latch_bit    = 1'b1;
          bit_d        = fm_first_bit_i;
        end else if (out_free) begin
          out_load = 1'b1;
          if (is_full) begin
            res_d.status = ghtu_pkg::ST_FULL;
          end else begin
            // Append a fresh slot with generation zero
            slot_we_o       = 1'b1;
            slot_waddr_o    = IDX_W'(used_q);
            slot_wdata_o    = {1'b0, {GEN_BITS{1'b0}},
                               (req_q == ghtu_pkg::REQ_INSERT) ? elem_q
                                                               : {ELEM_BITS{1'b0}}};
            fm_ctrl_o.wr_en = 1'b1;
            fm_wr_bits_o    = fm_rd_bits_i & ~bit_mask;
            used_d          = used_q + CNT_W'(1);
            res_d.status    = ghtu_pkg::ST_OK;
            res_d.index     = ghtu_pkg::IDX_BITS'(used_q);
            res_d.hk        = hk_tag_i;
            res_d.dk        = dk_tag_i;
            res_d.valid     = 1'b1;
          end
        end
      end

      ghtu_pkg::S_SLOT: begin
        if (out_free) begin
          out_load = 1'b1;
          unique case (ghtu_pkg::req_e'(req_q))
            ghtu_pkg::REQ_INSERT, ghtu_pkg::REQ_INSERT_NEW: begin
              // Take the free slot and bump its generation
              slot_we_o       = 1'b1;
              slot_waddr_o    = IDX_W'({row_q, bit_q});
              slot_wdata_o    = {1'b0, gen_inc,
                                 (req_q == ghtu_pkg::REQ_INSERT) ? elem_q : word_elem};
              fm_ctrl_o.wr_en = 1'b1;
              fm_wr_bits_o    = fm_rd_bits_i & ~bit_mask;
              res_d.status    = ghtu_pkg::ST_OK;
              res_d.index     = ghtu_pkg::IDX_BITS'({row_q, bit_q});
              res_d.gen       = ghtu_pkg::PORT_GEN_BITS'(gen_inc);
              res_d.hk        = hk_tag_i;
              res_d.dk        = dk_tag_i;
              res_d.valid     = 1'b1;
            end
            ghtu_pkg::REQ_REMOVE: begin
              // Free the slot only behind a live handle
              slot_we_o       = hval;
              slot_wdata_o    = {1'b1, word_gen, word_elem};
              fm_ctrl_o.wr_en = hval;
              fm_wr_bits_o    = fm_rd_bits_i | bit_mask;
              res_d.status    = hval ? ghtu_pkg::ST_OK : ghtu_pkg::ST_INVALID;
              res_d.index     = idx_q;
              res_d.gen       = gen_q;
              res_d.hk        = hk_q;
              res_d.dk        = dk_q;
            end
            ghtu_pkg::REQ_GET_HANDLE: begin
              res_d.status = hval ? ghtu_pkg::ST_OK : ghtu_pkg::ST_INVALID;
              res_d.index  = idx_q;
              res_d.gen    = gen_q;
              res_d.hk     = hk_q;
              res_d.dk     = dk_q;
              res_d.valid  = hval;
              res_d.elem   = hval ? ghtu_pkg::PORT_ELEM_BITS'(word_elem) : '0;
            end
            ghtu_pkg::REQ_GET_INDEX: begin
              // Slots past the used count read as generation zero
              res_d.status = ival ? ghtu_pkg::ST_OK : ghtu_pkg::ST_INVALID;
              res_d.index  = idx_q;
              res_d.gen    = in_range ? ghtu_pkg::PORT_GEN_BITS'(word_gen) : '0;
              res_d.hk     = hk_tag_i;
              res_d.dk     = dk_tag_i;
              res_d.valid  = ival;
              res_d.elem   = ival ? ghtu_pkg::PORT_ELEM_BITS'(word_elem) : '0;
            end
            ghtu_pkg::REQ_CLEAR: begin
              used_d          = '0;
              fm_ctrl_o.clear = 1'b1;
              res_d.status    = ghtu_pkg::ST_OK;
            end
            default: begin
              res_d.status = ghtu_pkg::ST_INVALID;
            end
          endcase
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghtu_pkg::S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: request latch, slot position, response beat
  always_ff @(posedge clk_i) begin
    if (latch_req) begin
      req_q       <= req_type_i;
      idx_q       <= slot_index_i;
      gen_q       <= slot_generation_i;
      hk_q        <= handle_kind_i;
      dk_q        <= data_kind_i;
      elem_q      <= ELEM_BITS'(element_value_i);
      have_free_q <= fm_any_free_i;
      row_q       <= row_d;
    end
    if (latch_bit) begin
      bit_q <= bit_d;
    end
    if (out_load) begin
      res_q <= res_d;
    end
  end

  assign used_o            = used_q;
  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q.status;
  assign out_index_o       = res_q.index;
  assign out_generation_o  = res_q.gen;
  assign out_handle_kind_o = res_q.hk;
  assign out_data_kind_o   = res_q.dk;
  assign handle_valid_o    = res_q.valid;
  assign out_element_o     = res_q.elem;

endmodule

/* rtl/core/generational_handle_table_unit.sv */
// Top level of the generational handle table unit: config registers and wiring.
// Depends on ghtu_pkg, ghtu_ram, ghtu_free_map and ghtu_seq.
`timescale 1ns / 1ps

// A slot table that hands out handles of index, generation and two kind tags.
// One request is in flight at a time and every request returns one response
// beat. Remove, both gets, clear and an appending insert go from acceptance
// through S_SLOT (S_FIND for an append) to the response register; an insert
// reusing a freed slot goes through S_FIND and then S_SLOT, because the bitmap
// row must be read before the chosen slot's word; both memories register reads.
// The response register lets the next request enter while a response waits.
// Reset and clear take effect at once: slots at or past the used count read
// as empty with generation zero, so no memory clearing pass is needed.
// Configuration (the two kind tags) must be written only while the unit is idle; the block does not enforce this.
module generational_handle_table_unit #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned GEN_BITS  = 16,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]        cfg_data_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ghtu_pkg::REQ_BITS-1:0]        req_type_i,
  input  logic [ghtu_pkg::IDX_BITS-1:0]        slot_index_i,
  input  logic [ghtu_pkg::PORT_GEN_BITS-1:0]   slot_generation_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]        handle_kind_i,
  input  logic [ghtu_pkg::TAG_BITS-1:0]        data_kind_i,
  input  logic [ghtu_pkg::PORT_ELEM_BITS-1:0]  element_value_i,
  // response channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ghtu_pkg::STATUS_BITS-1:0]     status_o,
  output logic [ghtu_pkg::IDX_BITS-1:0]        out_index_o,
  output logic [ghtu_pkg::PORT_GEN_BITS-1:0]   out_generation_o,
  output logic [ghtu_pkg::TAG_BITS-1:0]        out_handle_kind_o,
  output logic [ghtu_pkg::TAG_BITS-1:0]        out_data_kind_o,
  output logic                                 handle_valid_o,
  output logic [ghtu_pkg::PORT_ELEM_BITS-1:0]  out_element_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned NROWS  = (CAPACITY + ghtu_pkg::FREE_ROW_BITS - 1) /
                                   ghtu_pkg::FREE_ROW_BITS;
  localparam int unsigned ROW_AW = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SW     = 1 + GEN_BITS + ELEM_BITS;

  logic [ghtu_pkg::TAG_BITS-1:0] hk_tag_q, dk_tag_q;

  logic                 slot_re, slot_we;
  logic [IDX_W-1:0]     slot_raddr, slot_waddr;
  logic [SW-1:0]        slot_rdata, slot_wdata;

  ghtu_pkg::fm_ctrl_t                    fm_ctrl;
  logic [ROW_AW-1:0]                     fm_rd_row, fm_wr_row, fm_first_row;
  logic [ghtu_pkg::FREE_ROW_BITS-1:0]    fm_wr_bits, fm_rd_bits;
  logic [ghtu_pkg::FREE_ROW_SHIFT-1:0]   fm_first_bit;
  logic                                  fm_any_free;
  logic [CNT_W-1:0]                      used;

  // Kind tag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hk_tag_q <= '0;
      dk_tag_q <= '0;
    end else if (cfg_we_i) begin
      unique case (ghtu_pkg::cfg_reg_e'(cfg_index_i))
        ghtu_pkg::CFG_HANDLE_KIND: hk_tag_q <= cfg_data_i;
        ghtu_pkg::CFG_DATA_KIND:   dk_tag_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Slot store: {free mark, generation, element} per slot
  ghtu_ram #(
    .WIDTH (SW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  ghtu_free_map #(
    .CAPACITY (CAPACITY)
  ) u_free_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (fm_ctrl),
    .rd_row_i    (fm_rd_row),
    .wr_row_i    (fm_wr_row),
    .wr_bits_i   (fm_wr_bits),
    .used_i      (used),
    .any_free_o  (fm_any_free),
    .first_row_o (fm_first_row),
    .rd_bits_o   (fm_rd_bits),
    .first_bit_o (fm_first_bit)
  );

  ghtu_seq #(
    .CAPACITY  (CAPACITY),
    .GEN_BITS  (GEN_BITS),
    .ELEM_BITS (ELEM_BITS)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .slot_index_i      (slot_index_i),
    .slot_generation_i (slot_generation_i),
    .handle_kind_i     (handle_kind_i),
    .data_kind_i       (data_kind_i),
    .element_value_i   (element_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .out_index_o       (out_index_o),
    .out_generation_o  (out_generation_o),
    .out_handle_kind_o (out_handle_kind_o),
    .out_data_kind_o   (out_data_kind_o),
    .handle_valid_o    (handle_valid_o),
    .out_element_o     (out_element_o),
    .hk_tag_i          (hk_tag_q),
    .dk_tag_i          (dk_tag_q),
    .slot_re_o         (slot_re),
    .slot_raddr_o      (slot_raddr),
    .slot_rdata_i      (slot_rdata),
    .slot_we_o         (slot_we),
    .slot_waddr_o      (slot_waddr),
    .slot_wdata_o      (slot_wdata),
    .fm_ctrl_o         (fm_ctrl),
    .fm_rd_row_o       (fm_rd_row),
    .fm_wr_row_o       (fm_wr_row),
    .fm_wr_bits_o      (fm_wr_bits),
    .used_o            (used),
    .fm_any_free_i     (fm_any_free),
    .fm_first_row_i    (fm_first_row),
    .fm_rd_bits_i      (fm_rd_bits),
    .fm_first_bit_i    (fm_first_bit)
  );

endmodule

/* rtl/core/ghtu_checker.sv */
// Port-level checker for the generational handle table unit, bound to the top.
// Depends on ghtu_pkg and generational_handle_table_unit_defines.svh.
`timescale 1ns / 1ps
`include "generational_handle_table_unit_defines.svh"

module ghtu_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [ghtu_pkg::STATUS_BITS-1:0]     status_o,
  input logic [ghtu_pkg::IDX_BITS-1:0]        out_index_o,
  input logic [ghtu_pkg::PORT_GEN_BITS-1:0]   out_generation_o,
  input logic                                 handle_valid_o,
  input logic [ghtu_pkg::PORT_ELEM_BITS-1:0]  out_element_o
);

  // Hold a stalled response beat
  `GHTU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // Drop ready once a request beat is taken: one request in flight
  `GHTU_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

  // A live handle only comes back with an ok status
  `GHTU_ASSERT_IMPL(a_live_is_ok, out_valid_o && handle_valid_o, status_o == ghtu_pkg::ST_OK)

  // A full table answers with an all-zero handle
  `GHTU_ASSERT_IMPL(a_full_zero, out_valid_o && status_o == ghtu_pkg::ST_FULL, out_index_o == '0 && out_generation_o == '0 && !handle_valid_o && out_element_o == '0)

endmodule

bind generational_handle_table_unit ghtu_checker u_checker (.*);
